### sv/filled_circle_span_generator_unit_macros.svh
// ---------------------------------------------------------------------------
// Filled circle span generator assertion macros
// Shared assertion shorthands; the asserting module supplies clk and rst.
// ---------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_UNIT_MACROS_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_UNIT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define FCSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define FCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  `FCSG_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### sv/fcsg_pkg.sv
// ---------------------------------------------------------------------------
// Filled circle span generator package
// Constants, widths and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fcsg_pkg;

  localparam int MAX_RADIUS = 40;
  localparam int COORD_BITS = 8;

  localparam int CENTER_W = 8;
  localparam int RADIUS_W = 6;
  localparam int SYMBOL_W = 8;
  localparam int SPAN_W   = 10;
  localparam int DEC_W    = 12;

  localparam logic [CENTER_W-1:0] CENTER_MASK = (COORD_BITS >= CENTER_W) ?
      {CENTER_W{1'b1}} : CENTER_W'((1 << COORD_BITS) - 1);
  localparam logic [RADIUS_W-1:0] RADIUS_LIMIT = RADIUS_W'(MAX_RADIUS);

  typedef struct packed {
    logic load;
    logic emit_a;
    logic emit_b;
  } fcsg_cmd_t;

  typedef struct packed {
    logic stop;
  } fcsg_stat_t;

endpackage

### sv/fcsg_ctrl.sv
// ---------------------------------------------------------------------------
// Filled circle span controller
// Sequences the two spans of each midpoint step and drives busy.
// ---------------------------------------------------------------------------
module fcsg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  fcsg_pkg::fcsg_stat_t stat,
  output fcsg_pkg::fcsg_cmd_t  cmd,
  output logic               busy
);
  import fcsg_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SPAN_A,
    SPAN_B
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.load   = start && !busy;
    cmd.emit_a = (state == SPAN_A);
    cmd.emit_b = (state == SPAN_B);
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) begin
          state_next = SPAN_A;
        end
      end
      SPAN_A: begin
        state_next = SPAN_B;
      end
      SPAN_B: begin
        state_next = stat.stop ? IDLE : SPAN_A;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

endmodule

### sv/fcsg_datapath.sv
// ---------------------------------------------------------------------------
// Filled circle span datapath
// Holds the circle command, runs the midpoint terms and registers each span.
// ---------------------------------------------------------------------------
module fcsg_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fcsg_pkg::fcsg_cmd_t              cmd,
  output fcsg_pkg::fcsg_stat_t             stat,
  input  logic [fcsg_pkg::CENTER_W-1:0]    center_col,
  input  logic [fcsg_pkg::CENTER_W-1:0]    center_row,
  input  logic [fcsg_pkg::RADIUS_W-1:0]    circle_radius,
  input  logic [fcsg_pkg::SYMBOL_W-1:0]    fill_symbol,
  output logic                             strobe,
  output logic signed [fcsg_pkg::SPAN_W-1:0] row_upper,
  output logic signed [fcsg_pkg::SPAN_W-1:0] row_lower,
  output logic signed [fcsg_pkg::SPAN_W-1:0] col_left,
  output logic signed [fcsg_pkg::SPAN_W-1:0] col_right,
  output logic [fcsg_pkg::SYMBOL_W-1:0]    span_symbol,
  output logic                             last_span
);
  import fcsg_pkg::*;

  logic [CENTER_W-1:0]     held_col;
  logic [CENTER_W-1:0]     held_row;
  logic [SYMBOL_W-1:0]     held_symbol;
  logic [RADIUS_W-1:0]     step_x;
  logic [RADIUS_W-1:0]     step_y;
  logic signed [DEC_W-1:0] decision;

  logic [RADIUS_W-1:0]     radius_sat;
  logic [RADIUS_W-1:0]     step_x_next;
  logic [RADIUS_W-1:0]     step_y_next;
  logic signed [DEC_W-1:0] decision_next;
  logic signed [DEC_W-1:0] step_diff;
  logic signed [SPAN_W-1:0] cy;
  logic signed [SPAN_W-1:0] cx;
  logic signed [SPAN_W-1:0] xs;
  logic signed [SPAN_W-1:0] ys;
  logic signed [SPAN_W-1:0] roff;
  logic signed [SPAN_W-1:0] coff;

  always_comb begin
    radius_sat  = (circle_radius > RADIUS_LIMIT) ? RADIUS_LIMIT : circle_radius;
    step_x_next = step_x + RADIUS_W'(1);
    step_y_next = (decision > 0) ? (step_y - RADIUS_W'(1)) : step_y;
    step_diff   = $signed({{(DEC_W-RADIUS_W){1'b0}}, step_x_next}) -
                  $signed({{(DEC_W-RADIUS_W){1'b0}}, step_y_next});
    if (decision > 0) begin
      decision_next = decision + (step_diff <<< 2) + DEC_W'(10);
    end else begin
      decision_next = decision + $signed({{(DEC_W-RADIUS_W-2){1'b0}}, step_x_next, 2'b00})
                      + DEC_W'(6);
    end
    stat.stop = (decision > 0) ?
                ({1'b0, step_y} <= ({1'b0, step_x} + (RADIUS_W+1)'(1))) :
                (step_y <= step_x);
    cy   = $signed({{(SPAN_W-CENTER_W){1'b0}}, held_row});
    cx   = $signed({{(SPAN_W-CENTER_W){1'b0}}, held_col});
    xs   = $signed({{(SPAN_W-RADIUS_W){1'b0}}, step_x});
    ys   = $signed({{(SPAN_W-RADIUS_W){1'b0}}, step_y});
    roff = cmd.emit_b ? xs : ys;
    coff = cmd.emit_b ? ys : xs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe    <= 1'b0;
      last_span <= 1'b0;
    end else begin
      strobe    <= cmd.emit_a || cmd.emit_b;
      last_span <= cmd.emit_b && stat.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_col    <= center_col & CENTER_MASK;
      held_row    <= center_row & CENTER_MASK;
      held_symbol <= fill_symbol;
      step_x      <= '0;
      step_y      <= radius_sat;
      decision    <= DEC_W'(3) - $signed({{(DEC_W-RADIUS_W-1){1'b0}}, radius_sat, 1'b0});
    end else if (cmd.emit_b) begin
      step_x      <= step_x_next;
      step_y      <= step_y_next;
      decision    <= decision_next;
    end
    if (cmd.emit_a || cmd.emit_b) begin
      row_upper   <= cy - roff;
      row_lower   <= cy + roff;
      col_left    <= cx - coff;
      col_right   <= cx + coff;
      span_symbol <= held_symbol;
    end
  end

endmodule

### sv/filled_circle_span_generator_unit.sv
// ---------------------------------------------------------------------------
// Filled circle span generator
// Turns one circle command into horizontal fill spans by midpoint iteration.
//
//   Channel  Handshake               Ports
//   command  start && !busy          center_col center_row circle_radius
//                                    fill_symbol
//   span     strobe, one cycle       row_upper row_lower col_left col_right
//                                    span_symbol last_span
//
// A circle of N midpoint steps (about radius/sqrt(2) + 1) gives 2N spans,
// one per cycle from the shared step datapath.
// Spans appear in the cycle after the controller issues them.
// Synchronous reset returns the block to idle with no span pending.
// Spans cannot be stalled; each is valid for exactly its strobe cycle.
// ---------------------------------------------------------------------------
`include "filled_circle_span_generator_unit_macros.svh"

module filled_circle_span_generator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fcsg_pkg::CENTER_W-1:0]    center_col,
  input  logic [fcsg_pkg::CENTER_W-1:0]    center_row,
  input  logic [fcsg_pkg::RADIUS_W-1:0]    circle_radius,
  input  logic [fcsg_pkg::SYMBOL_W-1:0]    fill_symbol,
  output logic                             strobe,
  output logic signed [fcsg_pkg::SPAN_W-1:0] row_upper,
  output logic signed [fcsg_pkg::SPAN_W-1:0] row_lower,
  output logic signed [fcsg_pkg::SPAN_W-1:0] col_left,
  output logic signed [fcsg_pkg::SPAN_W-1:0] col_right,
  output logic [fcsg_pkg::SYMBOL_W-1:0]    span_symbol,
  output logic                             last_span
);
  import fcsg_pkg::*;

  fcsg_cmd_t  cmd;
  fcsg_stat_t stat;

  fcsg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fcsg_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .center_col    (center_col),
    .center_row    (center_row),
    .circle_radius (circle_radius),
    .fill_symbol   (fill_symbol),
    .strobe        (strobe),
    .row_upper     (row_upper),
    .row_lower     (row_lower),
    .col_left      (col_left),
    .col_right     (col_right),
    .span_symbol   (span_symbol),
    .last_span     (last_span)
  );

  `FCSG_ASSERT(a_last_has_strobe, last_span |-> strobe, "last span flagged without strobe")
  `FCSG_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted command did not set busy")
  `FCSG_ASSERT(a_more_spans_busy, strobe && !last_span |-> busy, "spans pending while idle")
  `FCSG_ASSERT(a_idle_ends_circle, $fell(busy) |-> strobe && last_span, "busy fell before last span")

endmodule

### bench/filled_circle_span_generator_unit_test.sv
// ---------------------------------------------------------------------------
// Filled circle span generator testbench
// Drives circle commands into the span generator and checks every span it
// emits against an in-bench midpoint circle predictor. A directed set covers
// zero, full and saturated radii with centers and symbols at their extremes.
// Random commands follow under several sender gap rates.
// ---------------------------------------------------------------------------
module filled_circle_span_generator_unit_test;
  import fcsg_pkg::*;

  localparam int SPAN_LIMIT = 64;

  typedef struct packed {
    logic [CENTER_W-1:0] col;
    logic [CENTER_W-1:0] row;
    logic [RADIUS_W-1:0] radius;
    logic [SYMBOL_W-1:0] symbol;
  } circle_cmd_t;

  typedef struct packed {
    logic signed [SPAN_W-1:0] row_upper;
    logic signed [SPAN_W-1:0] row_lower;
    logic signed [SPAN_W-1:0] col_left;
    logic signed [SPAN_W-1:0] col_right;
    logic [SYMBOL_W-1:0]      symbol;
    logic                     last;
  } span_t;

  logic                       clk;
  logic                       rst           = 1'b1;
  logic                       start         = 1'b0;
  logic                       busy;
  logic [CENTER_W-1:0]        center_col    = '0;
  logic [CENTER_W-1:0]        center_row    = '0;
  logic [RADIUS_W-1:0]        circle_radius = '0;
  logic [SYMBOL_W-1:0]        fill_symbol   = '0;
  logic                       strobe;
  logic signed [SPAN_W-1:0]   row_upper;
  logic signed [SPAN_W-1:0]   row_lower;
  logic signed [SPAN_W-1:0]   col_left;
  logic signed [SPAN_W-1:0]   col_right;
  logic [SYMBOL_W-1:0]        span_symbol;
  logic                       last_span;

  circle_cmd_t circle_q[$];
  span_t       expected_spans[$];
  int          gap_pct      = 0;
  bit          cmd_taken    = 1'b0;
  int          circles_sent = 0;
  int          circles_done = 0;
  int          spans_seen   = 0;
  int          error_count  = 0;

  filled_circle_span_generator_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .center_col    (center_col),
    .center_row    (center_row),
    .circle_radius (circle_radius),
    .fill_symbol   (fill_symbol),
    .strobe        (strobe),
    .row_upper     (row_upper),
    .row_lower     (row_lower),
    .col_left      (col_left),
    .col_right     (col_right),
    .span_symbol   (span_symbol),
    .last_span     (last_span)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic span_t make_span(int row, int roff, int col, int coff,
                                      logic [SYMBOL_W-1:0] sym);
    span_t s;
    s.row_upper = SPAN_W'(row - roff);
    s.row_lower = SPAN_W'(row + roff);
    s.col_left  = SPAN_W'(col - coff);
    s.col_right = SPAN_W'(col + coff);
    s.symbol    = sym;
    s.last      = 1'b0;
    return s;
  endfunction

  task automatic plan_circle_spans(circle_cmd_t c);
    int cx;
    int cy;
    int x;
    int y;
    int d;
    int n;
    cx = int'(c.col & CENTER_MASK);
    cy = int'(c.row & CENTER_MASK);
    y  = (int'(c.radius) > MAX_RADIUS) ? MAX_RADIUS : int'(c.radius);
    x  = 0;
    d  = 3 - 2 * y;
    n  = 0;
    while (y >= x && n + 2 <= SPAN_LIMIT) begin
      expected_spans.push_back(make_span(cy, y, cx, x, c.symbol));
      expected_spans.push_back(make_span(cy, x, cx, y, c.symbol));
      n += 2;
      x++;
      if (d > 0) begin
        y--;
        d = d + 4 * (x - y) + 10;
      end else begin
        d = d + 4 * x + 6;
      end
    end
    expected_spans[expected_spans.size()-1].last = 1'b1;
  endtask

  task automatic queue_circle(int col, int row, int radius, int sym);
    circle_cmd_t c;
    c.col    = CENTER_W'(col);
    c.row    = CENTER_W'(row);
    c.radius = RADIUS_W'(radius);
    c.symbol = SYMBOL_W'(sym);
    circle_q.push_back(c);
    circles_sent++;
  endtask

  task automatic queue_random_circles(int count);
    int radius;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        radius = $urandom_range(12);
      end else if (pick < 85) begin
        radius = $urandom_range(40);
      end else if (pick < 93) begin
        radius = $urandom_range(63, 41);
      end else begin
        radius = $urandom_range(40, 36);
      end
      queue_circle($urandom_range(255), $urandom_range(255), radius,
                   $urandom_range(255));
    end
  endtask

  always @(negedge clk) begin : drive
    circle_cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      cmd_taken = 1'b0;
      if (circle_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        c = circle_q.pop_front();
        start         <= 1'b1;
        center_col    <= c.col;
        center_row    <= c.row;
        circle_radius <= c.radius;
        fill_symbol   <= c.symbol;
      end else begin
        start         <= 1'b0;
        center_col    <= CENTER_W'($urandom);
        center_row    <= CENTER_W'($urandom);
        circle_radius <= RADIUS_W'($urandom);
        fill_symbol   <= SYMBOL_W'($urandom);
      end
    end
  end

  always @(posedge clk) begin : watch
    span_t want;
    circle_cmd_t c;
    if (!rst) begin
      if (strobe) begin
        spans_seen++;
        if (expected_spans.size() == 0) begin
          $error("Span with no expected transaction: rows %0d/%0d cols %0d..%0d",
                 row_upper, row_lower, col_left, col_right);
          error_count++;
        end else begin
          want = expected_spans.pop_front();
          if (row_upper !== want.row_upper) begin
            $error("row_upper: expected %0d, got %0d", want.row_upper, row_upper);
            error_count++;
          end
          if (row_lower !== want.row_lower) begin
            $error("row_lower: expected %0d, got %0d", want.row_lower, row_lower);
            error_count++;
          end
          if (col_left !== want.col_left) begin
            $error("col_left: expected %0d, got %0d", want.col_left, col_left);
            error_count++;
          end
          if (col_right !== want.col_right) begin
            $error("col_right: expected %0d, got %0d", want.col_right, col_right);
            error_count++;
          end
          if (span_symbol !== want.symbol) begin
            $error("span_symbol: expected %0d, got %0d", want.symbol, span_symbol);
            error_count++;
          end
          if (last_span !== want.last) begin
            $error("last_span: expected %0d, got %0d", want.last, last_span);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        c.col    = center_col;
        c.row    = center_row;
        c.radius = circle_radius;
        c.symbol = fill_symbol;
        plan_circle_spans(c);
        cmd_taken = 1'b1;
        circles_done++;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_pct = 0;
    queue_circle(0, 0, 0, 0);
    queue_circle(255, 255, 0, 255);
    queue_circle(128, 128, 1, 8'hA5);
    queue_circle(0, 0, 40, 8'h5A);
    queue_circle(255, 255, 40, 8'hFF);
    queue_circle(0, 255, 40, 8'h01);
    queue_circle(255, 0, 40, 8'h80);
    queue_circle(10, 20, 41, 8'h33);
    queue_circle(200, 100, 63, 8'hCC);
    queue_circle(5, 250, 48, 8'h0F);
    queue_circle(0, 255, 2, 8'hF0);
    queue_circle(255, 0, 3, 8'h55);
    queue_circle(100, 100, 4, 8'hAA);
    queue_circle(37, 91, 5, 8'h7E);
    queue_circle(170, 85, 8, 8'h81);
    queue_circle(85, 170, 16, 8'h42);
    queue_circle(64, 192, 32, 8'hBD);
    queue_circle(3, 3, 7, 8'h18);
    queue_circle(252, 252, 7, 8'hE7);
    while (circle_q.size() != 0) @(posedge clk);

    queue_random_circles(100);
    while (circle_q.size() != 0) @(posedge clk);

    gap_pct = 56;
    queue_random_circles(100);
    while (circle_q.size() != 0) @(posedge clk);

    gap_pct = 10;
    queue_random_circles(100);

    while (circles_done != circles_sent || expected_spans.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d spans from %0d circle commands, radii 0 to 63,",
             spans_seen, circles_done);
    $display("with sender gap rates of 0, 56 and 10 percent.");
    if (error_count == 0 && expected_spans.size() == 0) begin
      $display("filled_circle_span_generator_unit_test OK");
    end else begin
      $display("filled_circle_span_generator_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d spans still expected.", expected_spans.size());
    $display("filled_circle_span_generator_unit_test NOT OK");
    $finish;
  end

endmodule
